// File: hw/rtl/alm_pkg.sv
// Shared types, codes and widths for the array linked list manager.
package alm_pkg;

    localparam int ACTION_W = 3;
    localparam int PORT_IDX_W = 8;
    localparam int VALUE_W = 32;
    localparam int STATUS_W = 2;

    localparam logic [ACTION_W-1:0] ACT_INSERT_AFTER = 3'd0;
    localparam logic [ACTION_W-1:0] ACT_DELETE = 3'd1;
    localparam logic [ACTION_W-1:0] ACT_PUSH_HEAD = 3'd2;
    localparam logic [ACTION_W-1:0] ACT_PUSH_TAIL = 3'd3;
    localparam logic [ACTION_W-1:0] ACT_DELETE_HEAD = 3'd4;
    localparam logic [ACTION_W-1:0] ACT_DELETE_TAIL = 3'd5;

    localparam logic [STATUS_W-1:0] STS_OK = 2'd0;
    localparam logic [STATUS_W-1:0] STS_BAD_ANCHOR = 2'd1;
    localparam logic [STATUS_W-1:0] STS_FULL = 2'd2;

    typedef enum logic [2:0] {
        S_IDLE,
        S_READ,
        S_WRITE1,
        S_WRITE2,
        S_DONE
    } t_state;

    typedef struct packed {
        logic accept;
        logic read;
        logic write1;
        logic write2;
        logic load;
    } t_cmd;

    typedef struct packed {
        logic go;
        logic out_free;
    } t_stat;

endpackage

// File: hw/rtl/alm_ctrl.sv
// Sequencer that steps one request through read, one or two write phases and result load.
module alm_ctrl import alm_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_in_valid,
    input  t_stat i_stat,
    output logic  o_in_ready,
    output t_cmd  o_cmd
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = S_READ;
                end
            end
            S_READ: begin
                n_state = S_WRITE1;
            end
            S_WRITE1: begin
                n_state = i_stat.go ? S_WRITE2 : S_DONE;
            end
            S_WRITE2: begin
                n_state = S_DONE;
            end
            S_DONE: begin
                if (i_stat.out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        o_in_ready = 1'b0;
        o_cmd = '0;
        case (r_state)
            S_IDLE: begin
                o_in_ready = i_rst_n;
                o_cmd.accept = i_in_valid && i_rst_n;
            end
            S_READ: begin
                o_cmd.read = 1'b1;
            end
            S_WRITE1: begin
                o_cmd.write1 = 1'b1;
            end
            S_WRITE2: begin
                o_cmd.write2 = 1'b1;
            end
            S_DONE: begin
                o_cmd.load = i_stat.out_free;
            end
            default: begin
                o_cmd = '0;
            end
        endcase
    end

endmodule

// File: hw/rtl/alm_dp.sv
// Node store, list pointers, request decode and result register of the list manager.
module alm_dp import alm_pkg::*; #(
    parameter int NODE_COUNT = 256,
    parameter int DATA_WIDTH = 32
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  t_cmd                  i_cmd,
    input  logic                  i_out_ready,
    input  logic [ACTION_W-1:0]   i_action,
    input  logic [PORT_IDX_W-1:0] i_anchor_index,
    input  logic [VALUE_W-1:0]    i_element_value,
    output t_stat                 o_stat,
    output logic                  o_out_valid,
    output logic [STATUS_W-1:0]   o_status,
    output logic [PORT_IDX_W-1:0] o_new_index,
    output logic [PORT_IDX_W-1:0] o_head_index,
    output logic [PORT_IDX_W-1:0] o_tail_index
);

    localparam int IW = $clog2(NODE_COUNT);
    localparam logic [IW-1:0] LAST_NODE = IW'(NODE_COUNT - 1);

    // Nodes at or below r_top have never been allocated and read as unused free nodes, not from the store.
    // The sentinel's links live in r_head and r_tail.
    logic [IW-1:0]         mem_next [NODE_COUNT];
    logic [IW-1:0]         mem_prev [NODE_COUNT];
    logic                  mem_use [NODE_COUNT];
    logic [DATA_WIDTH-1:0] mem_data [NODE_COUNT];

    logic [IW-1:0]         r_head;
    logic [IW-1:0]         r_tail;
    logic [IW-1:0]         r_free_head;
    logic [IW-1:0]         r_top;

    logic [IW-1:0]         r_anc;
    logic                  r_anc_ok;
    logic                  r_is_ins;
    logic                  r_is_del;
    logic [DATA_WIDTH-1:0] r_value;

    logic [IW-1:0]         r_rd_anc_next;
    logic [IW-1:0]         r_rd_anc_prev;
    logic                  r_rd_anc_use;
    logic [IW-1:0]         r_rd_free_next;

    logic [STATUS_W-1:0]   r_status;
    logic [IW-1:0]         r_new;
    logic [IW-1:0]         r_fresh;
    logic [IW-1:0]         r_before;
    logic [IW-1:0]         r_after;

    logic                  r_out_valid;
    logic [STATUS_W-1:0]   r_o_status;
    logic [PORT_IDX_W-1:0] r_o_new;
    logic [PORT_IDX_W-1:0] r_o_head;
    logic [PORT_IDX_W-1:0] r_o_tail;

    logic [IW-1:0]         anchor_in;
    logic                  anchor_fits;
    logic [IW-1:0]         n_anc;
    logic                  n_anc_ok;
    logic                  n_is_ins;
    logic                  n_is_del;

    logic                  anc_virt;
    logic                  free_virt;
    logic [IW-1:0]         anc_next;
    logic [IW-1:0]         anc_prev;
    logic                  anc_use;
    logic [IW-1:0]         free_next;
    logic [STATUS_W-1:0]   w1_status;
    logic                  go;

    logic                  nx_we;
    logic [IW-1:0]         nx_addr;
    logic [IW-1:0]         nx_data;
    logic                  pv_we;
    logic [IW-1:0]         pv_addr;
    logic [IW-1:0]         pv_data;
    logic                  ud_we;
    logic [IW-1:0]         ud_addr;
    logic                  ud_use;
    logic [DATA_WIDTH-1:0] ud_data;

    assign anchor_in = IW'(i_anchor_index);
    assign anchor_fits = (32'(i_anchor_index) < 32'(NODE_COUNT));

    always_comb begin
        n_anc = '0;
        n_anc_ok = 1'b1;
        n_is_ins = 1'b0;
        n_is_del = 1'b0;
        case (i_action)
            ACT_INSERT_AFTER: begin
                n_anc = anchor_in;
                n_anc_ok = anchor_fits;
                n_is_ins = 1'b1;
            end
            ACT_DELETE: begin
                n_anc = anchor_in;
                n_anc_ok = anchor_fits;
                n_is_del = 1'b1;
            end
            ACT_PUSH_HEAD: begin
                n_is_ins = 1'b1;
            end
            ACT_PUSH_TAIL: begin
                n_anc = r_tail;
                n_is_ins = 1'b1;
            end
            ACT_DELETE_HEAD: begin
                n_anc = r_head;
                n_is_del = 1'b1;
            end
            ACT_DELETE_TAIL: begin
                n_anc = r_tail;
                n_is_del = 1'b1;
            end
            default: begin
                n_anc_ok = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_anc <= n_anc;
            r_anc_ok <= n_anc_ok;
            r_is_ins <= n_is_ins;
            r_is_del <= n_is_del;
            r_value <= DATA_WIDTH'(i_element_value);
        end
    end

    assign anc_virt = (r_anc <= r_top);
    assign free_virt = (r_free_head <= r_top);

    always_comb begin
        if (r_anc == '0) begin
            anc_next = r_head;
            anc_prev = r_tail;
            anc_use = 1'b1;
        end else if (anc_virt) begin
            anc_next = r_anc - IW'(1);
            anc_prev = '0;
            anc_use = 1'b0;
        end else begin
            anc_next = r_rd_anc_next;
            anc_prev = r_rd_anc_prev;
            anc_use = r_rd_anc_use;
        end
        free_next = free_virt ? (r_free_head - IW'(1)) : r_rd_free_next;
    end

    always_comb begin
        if (r_is_ins) begin
            if (!r_anc_ok || !anc_use) begin
                w1_status = STS_BAD_ANCHOR;
            end else if (r_free_head == '0) begin
                w1_status = STS_FULL;
            end else begin
                w1_status = STS_OK;
            end
        end else if (r_is_del) begin
            if (r_anc == '0 || !r_anc_ok || !anc_use) begin
                w1_status = STS_BAD_ANCHOR;
            end else begin
                w1_status = STS_OK;
            end
        end else begin
            w1_status = STS_BAD_ANCHOR;
        end
    end

    assign go = (w1_status == STS_OK);

    always_comb begin
        nx_we = 1'b0;
        nx_addr = '0;
        nx_data = '0;
        pv_we = 1'b0;
        pv_addr = '0;
        pv_data = '0;
        ud_we = 1'b0;
        ud_addr = '0;
        ud_use = 1'b0;
        ud_data = '0;
        if (i_cmd.write1 && go) begin
            nx_we = 1'b1;
            nx_addr = r_anc;
            nx_data = r_free_head;
            pv_we = 1'b1;
            ud_we = 1'b1;
            if (r_is_ins) begin
                pv_addr = anc_next;
                pv_data = r_free_head;
                ud_addr = r_free_head;
                ud_use = 1'b1;
                ud_data = r_value;
            end else begin
                pv_addr = r_anc;
                ud_addr = r_anc;
            end
        end else if (i_cmd.write2) begin
            nx_we = 1'b1;
            pv_we = 1'b1;
            if (r_is_ins) begin
                nx_addr = r_fresh;
                nx_data = r_after;
                pv_addr = r_fresh;
                pv_data = r_anc;
            end else begin
                nx_addr = r_before;
                nx_data = r_after;
                pv_addr = r_after;
                pv_data = r_before;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (nx_we) begin
            mem_next[nx_addr] <= nx_data;
        end
        if (i_cmd.read) begin
            r_rd_anc_next <= mem_next[r_anc];
            r_rd_free_next <= mem_next[r_free_head];
        end
    end

    always_ff @(posedge i_clk) begin
        if (pv_we) begin
            mem_prev[pv_addr] <= pv_data;
        end
        if (i_cmd.read) begin
            r_rd_anc_prev <= mem_prev[r_anc];
        end
    end

    always_ff @(posedge i_clk) begin
        if (ud_we) begin
            mem_use[ud_addr] <= ud_use;
        end
        if (i_cmd.read) begin
            r_rd_anc_use <= mem_use[r_anc];
        end
    end

    always_ff @(posedge i_clk) begin
        if (ud_we) begin
            mem_data[ud_addr] <= ud_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.write1) begin
            r_status <= w1_status;
            r_new <= (r_is_ins && go) ? r_free_head : '0;
            r_fresh <= r_free_head;
            r_before <= anc_prev;
            r_after <= anc_next;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head <= '0;
            r_tail <= '0;
            r_free_head <= LAST_NODE;
            r_top <= LAST_NODE;
        end else begin
            if (nx_we && nx_addr == '0) begin
                r_head <= nx_data;
            end
            if (pv_we && pv_addr == '0) begin
                r_tail <= pv_data;
            end
            if (i_cmd.write1 && go) begin
                r_free_head <= r_is_ins ? free_next : r_anc;
                if (r_is_ins && free_virt) begin
                    r_top <= r_free_head - IW'(1);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_o_status <= r_status;
            r_o_new <= PORT_IDX_W'(32'(r_new));
            r_o_head <= PORT_IDX_W'(32'(r_head));
            r_o_tail <= PORT_IDX_W'(32'(r_tail));
        end
    end

    assign o_stat.go = go;
    assign o_stat.out_free = !r_out_valid || i_out_ready;

    assign o_out_valid = r_out_valid;
    assign o_status = r_o_status;
    assign o_new_index = r_o_new;
    assign o_head_index = r_o_head;
    assign o_tail_index = r_o_tail;

endmodule

// File: hw/rtl/array_linked_list_manager_core.sv
// Top level of the array linked list manager: sequencer, node store and checks.
// The block keeps one circular doubly linked list in a store of NODE_COUNT nodes.
// Node 0 is the sentinel; unused nodes sit on a free list.
// The input channel (i_in_valid / o_in_ready) carries one request: an action code,
// an anchor index and a data word. The output channel (o_out_valid / i_out_ready)
// returns one result per request: status, new node index, head and tail indices.
// A request is taken only while the sequencer is idle. It then passes through the
// registered read of the anchor and free-head links, one or two link-write phases
// (the next and prev stores each take one write a cycle, and a splice or unlink
// needs two of each), and the load of the result register. A refused request
// skips the second write phase, and a new request is taken only once the result
// of the previous one has been loaded.
// Reset empties the list at once: nodes that were never allocated read as fresh,
// so no sweep of the store follows reset.
// If the receiver stalls, the result waits in the output register; the next
// request may be taken, but its result is held back until the register frees up.
module array_linked_list_manager_core import alm_pkg::*; #(
    parameter int NODE_COUNT = 256,
    parameter int DATA_WIDTH = 32
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  logic [ACTION_W-1:0]   i_action,
    input  logic [PORT_IDX_W-1:0] i_anchor_index,
    input  logic [VALUE_W-1:0]    i_element_value,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output logic [STATUS_W-1:0]   o_status,
    output logic [PORT_IDX_W-1:0] o_new_index,
    output logic [PORT_IDX_W-1:0] o_head_index,
    output logic [PORT_IDX_W-1:0] o_tail_index
);

    t_cmd  cmd;
    t_stat stat;

    alm_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_stat     (stat),
        .o_in_ready (o_in_ready),
        .o_cmd      (cmd)
    );

    alm_dp #(
        .NODE_COUNT (NODE_COUNT),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .i_out_ready     (i_out_ready),
        .i_action        (i_action),
        .i_anchor_index  (i_anchor_index),
        .i_element_value (i_element_value),
        .o_stat          (stat),
        .o_out_valid     (o_out_valid),
        .o_status        (o_status),
        .o_new_index     (o_new_index),
        .o_head_index    (o_head_index),
        .o_tail_index    (o_tail_index)
    );

`ifndef ASSERT_OFF
    a_accept_then_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.accept |=> cmd.read)
        else $error("accepted request was not followed by a read");

    a_second_write_follows_first: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.write2 |-> $past(cmd.write1))
        else $error("second write phase without a first");

    a_load_needs_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.load |-> (!o_out_valid || i_out_ready))
        else $error("result loaded over one not yet taken");

    a_one_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({cmd.accept, cmd.read, cmd.write1, cmd.write2, cmd.load}))
        else $error("more than one sequencer phase active");
`endif

endmodule
